### rtl/core/ptcr_pkg.sv
package ptcr_pkg;

  // Fixed field widths of the stream payloads
  localparam int unsigned AddrW   = 12;
  localparam int unsigned PhysW   = 11;
  localparam int unsigned EvPageW = 4;
  localparam int unsigned CountW  = 16;
  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 40;

  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

  // Commands from the controller to the datapath
  typedef struct packed {
    logic clr_wr;    // clear one page table entry
    logic load_in;   // capture a new request
    logic hit;       // page present: mark frame used
    logic fill;      // page missing, take next free frame
    logic sweep;     // one clock hand step
    logic evict;     // drop the victim page from the page table
    logic install;   // map the page into the swept frame
    logic out_load;  // move the result into the output register
  } ptcr_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic clr_last;     // last page table entry being cleared
    logic pt_present;   // page table read data says present
    logic frames_free;  // at least one frame never filled
    logic hand_used;    // use bit of the frame under the hand
    logic out_busy;     // output register holds an untaken result
  } ptcr_sts_t;

endpackage

### rtl/core/ptcr_ram.sv
module ptcr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Single port, read-first, registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/ptcr_ctrl.sv
module ptcr_ctrl
  import ptcr_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  ptcr_sts_t sts_i,
  output ptcr_cmd_t cmd_o
);

  localparam logic [2:0] StClear   = 3'd0;
  localparam logic [2:0] StIdle    = 3'd1;
  localparam logic [2:0] StLook    = 3'd2;
  localparam logic [2:0] StDecide  = 3'd3;
  localparam logic [2:0] StSweep   = 3'd4;
  localparam logic [2:0] StVictim  = 3'd5;
  localparam logic [2:0] StInstall = 3'd6;
  localparam logic [2:0] StDone    = 3'd7;

  logic [2:0] state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      StClear: begin
        cmd_o.clr_wr = 1'b1;
        if (sts_i.clr_last) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = StLook;
        end
      end
      StLook: begin
        state_d = StDecide;
      end
      StDecide: begin
        if (sts_i.pt_present) begin
          cmd_o.hit = 1'b1;
          state_d   = StDone;
        end else if (sts_i.frames_free) begin
          cmd_o.fill = 1'b1;
          state_d    = StDone;
        end else begin
          state_d = StSweep;
        end
      end
      StSweep: begin
        cmd_o.sweep = 1'b1;
        if (!sts_i.hand_used) begin
          state_d = StVictim;
        end
      end
      StVictim: begin
        cmd_o.evict = 1'b1;
        state_d     = StInstall;
      end
      StInstall: begin
        cmd_o.install = 1'b1;
        state_d       = StDone;
      end
      StDone: begin
        if (!sts_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### rtl/core/ptcr_dp.sv
module ptcr_dp
  import ptcr_pkg::*;
#(
  parameter int unsigned PageBytes  = 256,
  parameter int unsigned PageCount  = 16,
  parameter int unsigned FrameCount = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [AddrW-1:0]     addr_i,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output logic [PhysW-1:0]     phys_o,
  output logic                 fault_o,
  output logic                 replaced_o,
  output logic [EvPageW-1:0]   ev_page_o,
  output logic [CountW-1:0]    count_o,
  input  ptcr_cmd_t            cmd_i,
  output ptcr_sts_t            sts_o
);

  localparam int unsigned PW   = $clog2(PageCount);
  localparam int unsigned FW   = $clog2(FrameCount);
  localparam int unsigned OW   = $clog2(PageBytes);
  localparam int unsigned PtW  = FW + 1;
  localparam int unsigned PaW  = FW + OW;

  // Request and per-item registers
  logic [AddrW-1:0] addr_q;
  logic [FW-1:0]    frame_q;
  logic [PW-1:0]    victim_q;
  logic             fault_q, repl_q;

  // Frame state
  logic [FW:0]           fill_q;
  logic [FW-1:0]         hand_q;
  logic [FrameCount-1:0] used_q;
  logic [CountW-1:0]     cnt_q;
  logic [PW-1:0]         clr_q;

  // Output register
  logic               ovalid_q;
  logic [PhysW-1:0]   ophys_q;
  logic               ofault_q, orepl_q;
  logic [EvPageW-1:0] oev_q;
  logic [CountW-1:0]  ocnt_q;

  logic [PW-1:0]  page;
  logic [OW-1:0]  offset;
  logic [FW-1:0]  fill_idx;
  logic [FW-1:0]  hand_nxt;

  logic           pt_we;
  logic [PW-1:0]  pt_addr;
  logic [PtW-1:0] pt_wdata, pt_rdata;
  logic           own_we;
  logic [FW-1:0]  own_addr;
  logic [PW-1:0]  own_rdata;

  logic [PaW-1:0]      phys_full;
  logic [PaW+PhysW-1:0] phys_ext;
  logic [PW+EvPageW-1:0] victim_ext;

  // Address split
  assign page     = PW'((addr_q / PageBytes) % PageCount);
  assign offset   = OW'(addr_q % PageBytes);
  assign fill_idx = fill_q[FW-1:0];
  assign hand_nxt = (hand_q == FW'(FrameCount - 1)) ? '0 : hand_q + 1'b1;

  // Page table port: {present, frame}
  always_comb begin
    pt_we    = 1'b0;
    pt_addr  = page;
    pt_wdata = '0;
    priority if (cmd_i.clr_wr) begin
      pt_we   = 1'b1;
      pt_addr = clr_q;
    end else if (cmd_i.evict) begin
      pt_we   = 1'b1;
      pt_addr = own_rdata;
    end else if (cmd_i.install) begin
      pt_we    = 1'b1;
      pt_wdata = {1'b1, frame_q};
    end else if (cmd_i.fill) begin
      pt_we    = 1'b1;
      pt_wdata = {1'b1, fill_idx};
    end else begin
      pt_we = 1'b0;
    end
  end

  ptcr_ram #(.Width(PtW), .Depth(PageCount)) u_page_tbl (
    .clk_i  (clk_i),
    .we_i   (pt_we),
    .addr_i (pt_addr),
    .wdata_i(pt_wdata),
    .rdata_o(pt_rdata)
  );

  // Frame owner port: read at the hand, written on fill or install
  always_comb begin
    own_we   = cmd_i.install | cmd_i.fill;
    own_addr = hand_q;
    priority if (cmd_i.install) begin
      own_addr = frame_q;
    end else if (cmd_i.fill) begin
      own_addr = fill_idx;
    end else begin
      own_addr = hand_q;
    end
  end

  ptcr_ram #(.Width(PW), .Depth(FrameCount)) u_owner (
    .clk_i  (clk_i),
    .we_i   (own_we),
    .addr_i (own_addr),
    .wdata_i(page),
    .rdata_o(own_rdata)
  );

  // Control state of the frames
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q   <= '0;
      hand_q   <= '0;
      used_q   <= '0;
      cnt_q    <= '0;
      clr_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      if (cmd_i.clr_wr) begin
        clr_q <= clr_q + 1'b1;
      end
      if (cmd_i.hit) begin
        used_q[pt_rdata[FW-1:0]] <= 1'b1;
      end
      if (cmd_i.fill) begin
        used_q[fill_idx] <= 1'b1;
        fill_q           <= fill_q + 1'b1;
      end
      if (cmd_i.sweep) begin
        used_q[hand_q] <= 1'b0;
        hand_q         <= hand_nxt;
      end
      if (cmd_i.install) begin
        used_q[frame_q] <= 1'b1;
        if (cnt_q != CountMax) begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
      if (cmd_i.out_load) begin
        ovalid_q <= 1'b1;
      end else if (out_ready_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  // Per-item payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      addr_q   <= addr_i;
      fault_q  <= 1'b0;
      repl_q   <= 1'b0;
      victim_q <= '0;
    end
    if (cmd_i.hit) begin
      frame_q <= pt_rdata[FW-1:0];
    end
    if (cmd_i.fill) begin
      frame_q <= fill_idx;
      fault_q <= 1'b1;
    end
    if (cmd_i.sweep) begin
      frame_q <= hand_q;
      fault_q <= 1'b1;
    end
    if (cmd_i.evict) begin
      victim_q <= own_rdata;
    end
    if (cmd_i.install) begin
      repl_q <= 1'b1;
    end
  end

  // Physical address, truncated to the field width
  assign phys_full  = PaW'(frame_q) * PaW'(PageBytes) + PaW'(offset);
  assign phys_ext   = (PaW + PhysW)'(phys_full);
  assign victim_ext = (PW + EvPageW)'(victim_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      ophys_q  <= phys_ext[PhysW-1:0];
      ofault_q <= fault_q;
      orepl_q  <= repl_q;
      oev_q    <= repl_q ? victim_ext[EvPageW-1:0] : '0;
      ocnt_q   <= cnt_q;
    end
  end

  assign out_valid_o = ovalid_q;
  assign phys_o      = ophys_q;
  assign fault_o     = ofault_q;
  assign replaced_o  = orepl_q;
  assign ev_page_o   = oev_q;
  assign count_o     = ocnt_q;

  // Status
  assign sts_o.clr_last    = (clr_q == PW'(PageCount - 1));
  assign sts_o.pt_present  = pt_rdata[FW];
  assign sts_o.frames_free = (fill_q != (FW + 1)'(FrameCount));
  assign sts_o.hand_used   = used_q[hand_q];
  assign sts_o.out_busy    = ovalid_q & ~out_ready_i;

endmodule

### rtl/core/page_translate_clock_replace_unit.sv
// Page translation with clock (second chance) replacement.
// Slave stream: one logical address per request in s_axis_tdata[11:0].
// Master stream: one result per request: physical address, fault and
// replacement flags, evicted page and saturating replacement count.
// After reset the page table RAM is cleared, one entry a cycle, until all
// PAGE_COUNT entries are clear; s_axis_tready stays low during that pass.
// One request is in flight at a time. A present page is read from the
// page table, decided on and its result loaded into the output register,
// which raises m_axis_tvalid; the next request is taken only after that
// load. A miss with a free frame takes the same path. A miss with all
// frames full walks the clock hand, one frame per cycle, for 1 to
// FRAME_COUNT + 1 steps, then uses the single-port page table for an
// evict and then an install before its result is loaded.
// The result sits in an output register; while the receiver stalls the
// next request is still accepted and processed, and waits for the output
// register to free up before its result is loaded.
module page_translate_clock_replace_unit
  import ptcr_pkg::*;
#(
  parameter int unsigned PAGE_BYTES  = 256,
  parameter int unsigned PAGE_COUNT  = 16,
  parameter int unsigned FRAME_COUNT = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [11:0] virt_addr
  input  logic [InDataW-1:0]  s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [10:0] phys_addr, [11] fault, [12] replaced,
  // [16:13] evicted_page, [32:17] replacement_count
  output logic [OutDataW-1:0] m_axis_tdata
);

  ptcr_cmd_t          cmd;
  ptcr_sts_t          sts;
  logic [PhysW-1:0]   phys;
  logic               fault, replaced;
  logic [EvPageW-1:0] ev_page;
  logic [CountW-1:0]  count;

  ptcr_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  ptcr_dp #(
    .PageBytes (PAGE_BYTES),
    .PageCount (PAGE_COUNT),
    .FrameCount(FRAME_COUNT)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .addr_i     (s_axis_tdata[AddrW-1:0]),
    .out_ready_i(m_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .phys_o     (phys),
    .fault_o    (fault),
    .replaced_o (replaced),
    .ev_page_o  (ev_page),
    .count_o    (count),
    .cmd_i      (cmd),
    .sts_o      (sts)
  );

  // Pack the result, zero filled to whole bytes
  assign m_axis_tdata = {
    (OutDataW - PhysW - 2 - EvPageW - CountW)'(0),
    count, ev_page, replaced, fault, phys
  };

endmodule
